@@ src/url_percent_codec_top_defines.svh @@
// Assertion macros shared by the codec checker.
`ifndef URL_PERCENT_CODEC_TOP_DEFINES_SVH
`define URL_PERCENT_CODEC_TOP_DEFINES_SVH

// Assertion sampled on the rising clock, muted while reset is high.
`define UPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion sampled on the rising clock, also live during reset.
`define UPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/upc_pkg.sv @@
// Shared types, constants and character helpers of the URL percent codec.
package upc_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;

  // Configuration register indexes
  localparam logic REG_DIRECTION     = 1'b0;
  localparam logic REG_SPACE_AS_PLUS = 1'b1;

  typedef enum logic [1:0] {
    CMD_EMPTY,
    CMD_BYTE,
    CMD_ESC
  } cmd_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW
  } esc_phase_t;

  // One queued request for the output sequencer
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  value;
    logic        string_end;
    logic        bad;
  } cmd_t;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return HEX_DIGITS[nib];
  endfunction

  // Letters, digits, byte zero and the listed specials
  function automatic logic is_allowed(input logic [7:0] b);
    logic alnum;
    logic special;
    alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
            (b >= 8'h61 && b <= 8'h7A);
    special = (b == 8'h25) || (b == 8'h2B) || (b == 8'h3B) || (b == 8'h3F) ||
              (b == 8'h3A) || (b == 8'h40) || (b == 8'h3D) || (b == 8'h26) ||
              (b == 8'h2C) || (b == 8'h20) || (b == 8'h24) || (b == 8'h2F) ||
              (b == 8'h2D) || (b == 8'h5F) || (b == 8'h21) || (b == 8'h2E) ||
              (b == 8'h7E) || (b == 8'h2A) || (b == 8'h28) || (b == 8'h29);
    return (b == 8'h00) || alnum || special;
  endfunction

  // Bit 4 set marks a byte that is no hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = {1'b0, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = {1'b0, 4'(b - 8'h37)};
    end
    return v;
  endfunction

endpackage

@@ src/upc_channel_if.sv @@
// Handshake channel interfaces for input bytes, results and configuration writes.
interface upc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       run_last;
  logic       string_end;
  logic       bad;
  modport source (output valid, output out_byte, output byte_present,
                  output run_last, output string_end, output bad, input ready);
  modport sink   (input valid, input out_byte, input byte_present,
                  input run_last, input string_end, input bad, output ready);
endinterface

interface upc_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/url_percent_codec_top.sv @@
// An accepted byte's request is queued, then its result goes to the output register.
// Throughput: one input byte per cycle while the queue is not full; an encode escape
// holds the sequencer for its three results, and the two-entry queue backs up the input.
// Reset (synchronous, active high) clears the escape and error state, both registers,
// the request queue, the output valid flag and the sequencer step.
// Top level of the byte-serial URL percent codec.
module url_percent_codec_top
  import upc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  upc_in_if.sink    req,
  upc_out_if.source rsp,
  upc_cfg_if.sink   cfg
);

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  upc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  upc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  upc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule

@@ src/upc_front.sv @@
// Front end: accepts bytes, tracks escape and error state, queues output requests.
module upc_front
  import upc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  upc_in_if.sink    req,
  upc_cfg_if.sink   cfg,
  input  logic      queue_full,
  output logic      push,
  output cmd_t      push_cmd
);

  logic       direction;
  logic       space_as_plus;
  esc_phase_t phase, phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       error_seen, error_seen_next;

  logic       accept;
  logic       cfg_we;
  logic [4:0] hv;
  logic       allowed;

  // Per-item results before the end-of-string handling
  esc_phase_t phase_mid;
  logic [3:0] nibble_mid;
  logic       error_mid;
  cmd_kind_t  kind_mid;
  logic [7:0] value_mid;

  assign req.ready = !queue_full;
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;
  assign cfg_we    = cfg.valid && cfg.ready;
  assign hv        = hex_value(req.in_byte);
  assign allowed   = is_allowed(req.in_byte);

  // Classify the byte against the current escape state
  always_comb begin
    phase_mid  = phase;
    nibble_mid = high_nibble;
    error_mid  = error_seen;
    kind_mid   = CMD_EMPTY;
    value_mid  = req.in_byte;
    if (!error_seen) begin
      if (!direction) begin
        if (req.in_byte == CH_SPACE && space_as_plus) begin
          kind_mid  = CMD_BYTE;
          value_mid = CH_PLUS;
        end else if (req.in_byte == CH_BACKSLASH) begin
          kind_mid  = CMD_BYTE;
          value_mid = CH_SLASH;
        end else if (allowed) begin
          kind_mid = CMD_BYTE;
        end else begin
          kind_mid = CMD_ESC;
        end
      end else begin
        case (phase)
          PH_HIGH: begin
            if (hv[4]) begin
              error_mid  = 1'b1;
              phase_mid  = PH_IDLE;
              nibble_mid = '0;
            end else begin
              nibble_mid = hv[3:0];
              phase_mid  = PH_LOW;
            end
          end
          PH_LOW: begin
            if (hv[4]) begin
              error_mid = 1'b1;
            end else begin
              kind_mid  = CMD_BYTE;
              value_mid = {high_nibble, hv[3:0]};
            end
            phase_mid  = PH_IDLE;
            nibble_mid = '0;
          end
          default: begin
            phase_mid = PH_IDLE;
            if (req.in_byte == CH_PERCENT) begin
              phase_mid = PH_HIGH;
            end else if (allowed) begin
              kind_mid = CMD_BYTE;
            end else begin
              error_mid = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Next escape and error state
  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    error_seen_next  = error_seen;
    if (cfg_we && cfg.index == REG_DIRECTION) begin
      phase_next       = PH_IDLE;
      high_nibble_next = '0;
    end else if (accept) begin
      if (req.in_last) begin
        phase_next       = PH_IDLE;
        high_nibble_next = '0;
        error_seen_next  = 1'b0;
      end else begin
        phase_next       = phase_mid;
        high_nibble_next = nibble_mid;
        error_seen_next  = error_mid;
      end
    end
  end

  // Build the request; the last byte always closes the string
  always_comb begin
    push_cmd.kind       = kind_mid;
    push_cmd.value      = value_mid;
    push_cmd.string_end = req.in_last;
    push_cmd.bad        = req.in_last && (error_mid || (phase_mid == PH_HIGH) ||
                                          (phase_mid == PH_LOW));
    push = accept && (req.in_last || kind_mid != CMD_EMPTY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= 1'b0;
      space_as_plus <= 1'b0;
      phase         <= PH_IDLE;
      high_nibble   <= '0;
      error_seen    <= 1'b0;
    end else begin
      if (cfg_we && cfg.index == REG_DIRECTION) begin
        direction <= cfg.data;
      end
      if (cfg_we && cfg.index == REG_SPACE_AS_PLUS) begin
        space_as_plus <= cfg.data;
      end
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      error_seen  <= error_seen_next;
    end
  end

endmodule

@@ src/upc_queue.sv @@
// Short request queue between front end and output sequencer.
module upc_queue
  import upc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd,
  input  logic pop
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/upc_back.sv @@
// Output sequencer: expands each request into one or three registered results.
module upc_back
  import upc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     head_valid,
  input  cmd_t     head_cmd,
  output logic     pop,
  upc_out_if.source rsp
);

  logic [1:0] step, step_next;
  logic       load;
  logic       final_step;

  logic [7:0] nxt_byte;
  logic       nxt_present;
  logic       nxt_run_last;
  logic       nxt_end;
  logic       nxt_bad;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       run_last;
  logic       string_end;
  logic       bad;

  assign load = head_valid && (!out_valid || rsp.ready);

  // Select the result for the current step of the head request
  always_comb begin
    nxt_byte     = head_cmd.value;
    nxt_present  = 1'b1;
    final_step   = 1'b1;
    case (head_cmd.kind)
      CMD_ESC: begin
        case (step)
          2'd0: begin
            nxt_byte   = CH_PERCENT;
            final_step = 1'b0;
          end
          2'd1: begin
            nxt_byte   = hex_char(head_cmd.value[7:4]);
            final_step = 1'b0;
          end
          default: begin
            nxt_byte = hex_char(head_cmd.value[3:0]);
          end
        endcase
      end
      CMD_BYTE: begin
        nxt_byte = head_cmd.value;
      end
      default: begin
        nxt_byte    = '0;
        nxt_present = 1'b0;
      end
    endcase
    nxt_run_last = final_step;
    nxt_end      = final_step && head_cmd.string_end;
    nxt_bad      = final_step && head_cmd.bad;
  end

  // Advance the step; release the request on its final result
  always_comb begin
    pop       = load && final_step;
    step_next = step;
    if (load) begin
      step_next = final_step ? 2'd0 : step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result payload until taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= nxt_byte;
      byte_present <= nxt_present;
      run_last     <= nxt_run_last;
      string_end   <= nxt_end;
      bad          <= nxt_bad;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.out_byte     = out_byte;
  assign rsp.byte_present = byte_present;
  assign rsp.run_last     = run_last;
  assign rsp.string_end   = string_end;
  assign rsp.bad          = bad;

endmodule

@@ src/upc_checker.sv @@
// Port-level checker for the URL percent codec, bound to the top level.
`include "url_percent_codec_top_defines.svh"

module upc_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_out_byte,
  input logic       rsp_byte_present,
  input logic       rsp_run_last,
  input logic       rsp_string_end,
  input logic       rsp_bad
);

  // A string's closing result always ends its input's run
  `UPC_ASSERT(a_end_is_run_last, clk, rst, rsp_valid && rsp_string_end |-> rsp_run_last, "string end without run end")

  // The error flag only shows on a closing result
  `UPC_ASSERT(a_bad_only_at_end, clk, rst, rsp_valid && rsp_bad |-> rsp_string_end, "bad flag off string end")

  // An empty result only closes a string and carries a zero byte
  `UPC_ASSERT(a_empty_closes, clk, rst, rsp_valid && !rsp_byte_present |-> rsp_string_end && rsp_run_last && rsp_out_byte == 8'h00, "stray empty result")

  // A stalled result stays offered
  `UPC_ASSERT(a_hold_stalled, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid, "stalled result dropped")

endmodule

bind url_percent_codec_top upc_checker u_upc_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_out_byte     (rsp.out_byte),
  .rsp_byte_present (rsp.byte_present),
  .rsp_run_last     (rsp.run_last),
  .rsp_string_end   (rsp.string_end),
  .rsp_bad          (rsp.bad)
);

@@ verif/testbench.sv @@
// Self-checking testbench of the URL percent codec: directed table, then random strings.
module testbench;
  import upc_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int BURST_ITEMS   = 15;
  localparam int HOLD_CYCLES   = 80;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       run_last;
    logic       string_end;
    logic       bad;
  } codec_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_WRITE
  } row_kind_t;

  // One line of the directed table: a byte request or a register write
  typedef struct packed {
    row_kind_t     kind;
    logic          widx;
    logic          wval;
    logic [7:0]    b;
    logic          last;
    logic          typed;
    codec_result_t want;
  } stim_row_t;

  localparam int N_ROWS = 34;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // encode, registers at reset values
    '{ROW_ITEM,  1'b0, 1'b0, 8'h41, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_ITEM,  1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h20, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h5C, 1'b1, 1'b1, '{8'h2F, 1'b1, 1'b1, 1'b1, 1'b0}},
    // encode with space as plus
    '{ROW_WRITE, REG_SPACE_AS_PLUS, 1'b1, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h20, 1'b1, 1'b1, '{8'h2B, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h80, 1'b1, 1'b0, '0},
    // decode: good escape, plus kept, cut-off escape, bad hex digits
    '{ROW_WRITE, REG_DIRECTION, 1'b1, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h25, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h34, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h61, 1'b1, 1'b1, '{8'h4A, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h2B, 1'b1, 1'b1, '{8'h2B, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h25, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h25, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h47, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h41, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h25, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h25, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h80, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h61, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0}},
    // direction change mid-escape drops the pending escape
    '{ROW_ITEM,  1'b0, 1'b0, 8'h25, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h46, 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_DIRECTION, 1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h41, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b1, 1'b1, 1'b0}},
    // direction change keeps a string error
    '{ROW_WRITE, REG_DIRECTION, 1'b1, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h7F, 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_DIRECTION, 1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_DIRECTION, 1'b1, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h61, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
    // back to plain encode
    '{ROW_WRITE, REG_SPACE_AS_PLUS, 1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_DIRECTION, 1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_ITEM,  1'b0, 1'b0, 8'h20, 1'b1, 1'b0, '0}
  };

  logic clk;
  logic rst;

  upc_in_if  req_ch ();
  upc_out_if rsp_ch ();
  upc_cfg_if cfg_ch ();

  url_percent_codec_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Codec state as the checker sees it
  logic       cfg_decode;
  logic       cfg_plus;
  esc_phase_t esc_state;
  logic [3:0] esc_high;
  logic       str_failed;

  string         url_marks = "%+;?:@=&, $/-_!.~*()";
  codec_result_t produced [$];
  codec_result_t expected_results [$];
  codec_result_t arrived_want;
  int            mismatches;
  int            burst_count;
  int            cycle_count;
  int            hold_left;
  int            src_idle_pct;
  int            sink_stall_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic url_safe(input logic [7:0] b);
    if (b == 8'h00) return 1'b1;
    if (b[7]) return 1'b0;
    if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
        (b >= 8'h61 && b <= 8'h7A)) return 1'b1;
    for (int k = 0; k < url_marks.len(); k++) begin
      if (8'(url_marks[k]) == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Bit 4 set when the byte is no hex digit
  function automatic logic [4:0] nibble_of(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return {1'b0, 4'(b - 8'h30)};
    if (b >= 8'h41 && b <= 8'h46) return {1'b0, 4'(b - 8'h41 + 8'd10)};
    if (b >= 8'h61 && b <= 8'h66) return {1'b0, 4'(b - 8'h61 + 8'd10)};
    return 5'h10;
  endfunction

  function automatic logic [7:0] hex_upper(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
  endfunction

  function automatic void emit(input logic [7:0] v);
    produced.insert(produced.size(), codec_result_t'{v, 1'b1, 1'b0, 1'b0, 1'b0});
  endfunction

  // Work out the results of one byte and advance the escape and error state
  function automatic void predict_codec(input logic [7:0] b, input logic last);
    logic [4:0] hv;
    int         n;
    produced.delete();
    if (!str_failed) begin
      if (!cfg_decode) begin
        if (b == CH_SPACE && cfg_plus) begin
          emit(CH_PLUS);
        end else if (b == CH_BACKSLASH) begin
          emit(CH_SLASH);
        end else if (url_safe(b)) begin
          emit(b);
        end else begin
          emit(CH_PERCENT);
          emit(hex_upper(b[7:4]));
          emit(hex_upper(b[3:0]));
        end
      end else if (esc_state == PH_HIGH || esc_state == PH_LOW) begin
        hv = nibble_of(b);
        if (hv[4]) begin
          str_failed = 1'b1;
          esc_state  = PH_IDLE;
          esc_high   = 4'h0;
        end else if (esc_state == PH_HIGH) begin
          esc_high  = hv[3:0];
          esc_state = PH_LOW;
        end else begin
          emit({esc_high, hv[3:0]});
          esc_state = PH_IDLE;
          esc_high  = 4'h0;
        end
      end else begin
        esc_state = PH_IDLE;
        if (b == CH_PERCENT) begin
          esc_state = PH_HIGH;
        end else if (url_safe(b)) begin
          emit(b);
        end else begin
          str_failed = 1'b1;
        end
      end
    end
    if (last) begin
      // an escape left open at the end is an error too
      if (esc_state != PH_IDLE) str_failed = 1'b1;
      if (produced.size() == 0) produced.insert(0, codec_result_t'('0));
      n = produced.size() - 1;
      produced[n].string_end = 1'b1;
      produced[n].bad        = str_failed;
      esc_state  = PH_IDLE;
      esc_high   = 4'h0;
      str_failed = 1'b0;
    end
    if (produced.size() > 0) produced[produced.size() - 1].run_last = 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Offer one byte, hold it until taken, then queue what it should produce
  task automatic offer(input logic [7:0] b, input logic last, input logic typed,
                       input codec_result_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.in_byte <= b;
    req_ch.in_last <= last;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_codec(b, last);
    if (typed) begin
      expected_results.insert(expected_results.size(), want);
    end else begin
      foreach (produced[k]) expected_results.insert(expected_results.size(), produced[k]);
    end
    burst_count++;
  endtask

  // Stop offering, wait for every pending result, then let the pipe empty
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_DIRECTION) begin
      cfg_decode = val;
      esc_state  = PH_IDLE;
      esc_high   = 4'h0;
    end else begin
      cfg_plus = val;
    end
  endtask

  function automatic logic [7:0] url_char(input logic with_pct);
    case ($urandom_range(3))
      0: return 8'h30 + 8'($urandom_range(9));
      1: return 8'h41 + 8'($urandom_range(25));
      2: return 8'h61 + 8'($urandom_range(25));
      default: return 8'(url_marks[$urandom_range(with_pct ? 0 : 1, url_marks.len() - 1)]);
    endcase
  endfunction

  function automatic logic [7:0] hex_any_case(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n - 4'd10);
  endfunction

  // Build one string suited to the current direction and send it
  task automatic send_random_string();
    int         len;
    int         roll;
    logic [7:0] v;
    logic [7:0] str [$];
    len = $urandom_range(1, 5);
    if (!cfg_decode) begin
      for (int k = 0; k < len; k++) begin
        roll = $urandom_range(99);
        if (roll < 35) str.insert(str.size(), 8'($urandom_range(255)));
        else if (roll < 50) str.insert(str.size(), CH_SPACE);
        else if (roll < 60) str.insert(str.size(), CH_BACKSLASH);
        else str.insert(str.size(), url_char(1'b1));
      end
    end else if ($urandom_range(99) < 70) begin
      // well-formed: plain characters and complete escapes
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(1)) begin
          v = 8'($urandom_range(255));
          str.insert(str.size(), CH_PERCENT);
          str.insert(str.size(), hex_any_case(v[7:4]));
          str.insert(str.size(), hex_any_case(v[3:0]));
        end else begin
          str.insert(str.size(), url_char(1'b0));
        end
      end
    end else begin
      // noise: stray bytes, broken and cut-off escapes
      for (int k = 0; k < len; k++) begin
        roll = $urandom_range(99);
        if (roll < 40) str.insert(str.size(), 8'($urandom_range(255)));
        else if (roll < 70) str.insert(str.size(), CH_PERCENT);
        else str.insert(str.size(), url_char(1'b1));
      end
    end
    foreach (str[k]) offer(str[k], k == str.size() - 1, 1'b0, '0);
  endtask

  // Receiver: long hold when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result with no request pending", rsp_ch.out_byte, 0);
      end else begin
        arrived_want = expected_results.pop_front();
        if (rsp_ch.out_byte != arrived_want.data)
          note_mismatch("out_byte", rsp_ch.out_byte, arrived_want.data);
        if (rsp_ch.byte_present != arrived_want.present)
          note_mismatch("byte_present", rsp_ch.byte_present, arrived_want.present);
        if (rsp_ch.run_last != arrived_want.run_last)
          note_mismatch("run_last", rsp_ch.run_last, arrived_want.run_last);
        if (rsp_ch.string_end != arrived_want.string_end)
          note_mismatch("string_end", rsp_ch.string_end, arrived_want.string_end);
        if (rsp_ch.bad != arrived_want.bad)
          note_mismatch("bad", rsp_ch.bad, arrived_want.bad);
      end
    end
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.in_byte = 8'h00;
    req_ch.in_last = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_DIRECTION;
    cfg_ch.data    = 1'b0;
    rsp_ch.ready   = 1'b0;
    cfg_decode     = 1'b0;
    cfg_plus       = 1'b0;
    esc_state      = PH_IDLE;
    esc_high       = 4'h0;
    str_failed     = 1'b0;
    mismatches     = 0;
    cycle_count    = 0;
    hold_left      = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(DIRECTED[r].widx, DIRECTED[r].wval);
      end else begin
        cfg_ch.valid <= 1'b0;
        offer(DIRECTED[r].b, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    // Random strings: four idling patterns, each over all register settings
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
        default: begin src_idle_pct = 12; sink_stall_pct = 12; end
      endcase
      for (int s = 0; s < 4; s++) begin
        wait_drained();
        write_reg(REG_DIRECTION, s[1]);
        write_reg(REG_SPACE_AS_PLUS, s[0]);
        cfg_ch.valid <= 1'b0;
        // hold the receiver off so the queue backs up into the input
        if (p == 0 && s == 0) hold_left = HOLD_CYCLES;
        burst_count = 0;
        while (burst_count < BURST_ITEMS) send_random_string();
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
